// ===== rtl/m64h_pkg.sv =====
// Shared constants, types and helper functions for the streaming 64-bit hash block.
package m64h_pkg;

   localparam int WORD_W   = 64;
   localparam int HALF_W   = 32;
   localparam int COUNT_W  = 4;
   localparam int ADDR_W   = 4;
   localparam int SHIFT_W  = 3;

   localparam logic [WORD_W-1:0]  MIX_MULT   = 64'hc6a4_a793_5bd1_e995;
   localparam logic [HALF_W-1:0]  MULT_LO    = MIX_MULT[HALF_W-1:0];
   localparam logic [HALF_W-1:0]  MULT_HI    = MIX_MULT[WORD_W-1:HALF_W];
   localparam int                 MIX_SHIFT  = 47;
   localparam logic [WORD_W-1:0]  SEED_RESET = 64'd53390;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
   localparam logic [COUNT_W-1:0] ZERO_COUNT = 4'd0;

   // register index taken from paddr[3]
   localparam logic               REG_SEED   = 1'b0;

   // multiply passes: low x low, low x high, high x low, then post-mix
   localparam logic [1:0] STEP_LL   = 2'd0;
   localparam logic [1:0] STEP_LH   = 2'd1;
   localparam logic [1:0] STEP_HL   = 2'd2;
   localparam logic [1:0] STEP_POST = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_KEY1,
      PH_KEY2,
      PH_HASH,
      PH_FINAL
   } phase_type;

   function automatic logic [WORD_W-1:0] xor_shift(input logic [WORD_W-1:0] x);
      xor_shift = x ^ (x >> MIX_SHIFT);
   endfunction

   function automatic logic [WORD_W-1:0] byte_mask(input logic [SHIFT_W-1:0] n);
      byte_mask = ~({WORD_W{1'b1}} << {n, 3'b000});
   endfunction

endpackage

// ===== rtl/murmur64_hash_stream.sv =====
// Streaming 64-bit hash: sequencer around one shared 32x32 multiplier.
//
// Each 64-bit multiply by the mixing constant runs on the single 32x32
// multiplier as three partial products accumulated into the low 64 bits,
// then a post step that applies the following mixing step (an xor/shift,
// or the xor into the hash after the second key multiply). A full 8-byte
// word needs three such multiplies, a partial word one, an empty non-last
// item none; a last item adds one more multiply for the final avalanche.
// A new beat is not taken until the multiplies of the previous one are
// done, while empty non-last items may arrive every cycle. req_ready is
// high only while the sequencer is idle. The result sits in an output
// register, so a new message may start while the previous hash waits; a
// finishing hash holds until that register is free. The seed register
// (64 bits, address 0, reset 53390) gives the starting hash at the first
// beat of every message.
module murmur64_hash_stream
   import m64h_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [COUNT_W-1:0]  req_byte_count,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_hash_value,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [WORD_W-1:0]   pwdata,
   output logic [WORD_W-1:0]   prdata,
   output logic                pready
);

   phase_type           phase_ff, phase_in;
   logic [1:0]          step_ff, step_in;
   logic [WORD_W-1:0]   opa_ff, opa_in;
   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [WORD_W-1:0]   hash_ff, hash_in;
   logic                last_ff, last_in;
   logic                in_msg_ff, in_msg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_hash_ff, rsp_hash_in;
   logic [WORD_W-1:0]   seed_ff, seed_in;

   logic                accept;
   logic                out_free;
   logic [COUNT_W-1:0]  count;
   logic [WORD_W-1:0]   base_hash;
   logic [HALF_W-1:0]   mul_a, mul_b;
   logic [WORD_W-1:0]   prod;
   logic                seed_wr;

   assign req_ready      = (phase_ff == PH_IDLE);
   assign accept         = req_valid && req_ready;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign pready         = 1'b1;
   assign seed_wr        = psel && penable && pwrite && (paddr[3] == REG_SEED);
   assign prdata         = (paddr[3] == REG_SEED) ? seed_ff : '0;

   assign count     = (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;
   assign base_hash = in_msg_ff ? hash_ff : seed_ff;

   assign mul_a = (step_ff == STEP_HL) ? opa_ff[WORD_W-1:HALF_W] : opa_ff[HALF_W-1:0];
   assign mul_b = (step_ff == STEP_LH) ? MULT_HI : MULT_LO;
   assign prod  = mul_a * mul_b;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      case (phase_ff)
         PH_IDLE: begin
            step_in = STEP_LL;
            if (accept) begin
               if (count == FULL_COUNT) begin
                  phase_in = PH_KEY1;
               end else if (count != ZERO_COUNT) begin
                  phase_in = PH_HASH;
               end else if (req_last) begin
                  phase_in = PH_FINAL;
               end
            end
         end
         PH_KEY1, PH_KEY2, PH_HASH, PH_FINAL: begin
            if (step_ff != STEP_POST) begin
               step_in = step_ff + 2'd1;
            end else begin
               step_in = STEP_LL;
               case (phase_ff)
                  PH_KEY1: phase_in = PH_KEY2;
                  PH_KEY2: phase_in = PH_HASH;
                  PH_HASH: phase_in = last_ff ? PH_FINAL : PH_IDLE;
                  default: begin
                     if (out_free) begin
                        phase_in = PH_IDLE;
                     end else begin
                        step_in = STEP_POST;
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_IDLE;
            step_in  = STEP_LL;
         end
      endcase
   end

   always_comb begin
      opa_in       = opa_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      last_in      = last_ff;
      in_msg_in    = in_msg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      seed_in      = seed_wr ? pwdata : seed_ff;

      case (step_ff)
         STEP_LL: acc_in = prod;
         STEP_LH: acc_in = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
         STEP_HL: acc_in = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
         default: acc_in = acc_ff;
      endcase

      case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               hash_in   = base_hash;
               last_in   = req_last;
               in_msg_in = !req_last;
               if (count == FULL_COUNT) begin
                  opa_in = req_data_word;
               end else if (count != ZERO_COUNT) begin
                  opa_in = base_hash ^ (req_data_word & byte_mask(count[SHIFT_W-1:0]));
               end else begin
                  opa_in = xor_shift(base_hash);
               end
            end
         end
         PH_KEY1: begin
            if (step_ff == STEP_POST) begin
               opa_in = xor_shift(acc_ff);
            end
         end
         PH_KEY2: begin
            if (step_ff == STEP_POST) begin
               opa_in = hash_ff ^ acc_ff;
            end
         end
         PH_HASH: begin
            if (step_ff == STEP_POST) begin
               hash_in = acc_ff;
               opa_in  = xor_shift(acc_ff);
            end
         end
         PH_FINAL: begin
            if (step_ff == STEP_POST && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = xor_shift(acc_ff);
            end
         end
         default: begin
            opa_in = opa_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         step_ff      <= STEP_LL;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= SEED_RESET;
      end else begin
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff      <= opa_in;
      acc_ff      <= acc_in;
      hash_ff     <= hash_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

// ===== rtl/m64h_check.sv =====
// Port-level checker for the streaming hash block, bound to the top level.
module m64h_check
   import m64h_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [COUNT_W-1:0]  req_byte_count,
   input  logic                req_last,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [WORD_W-1:0]   rsp_hash_value,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [WORD_W-1:0]   pwdata,
   input  logic [WORD_W-1:0]   prdata,
   input  logic                pready
);

   logic req_beat;
   logic seed_write;

   assign req_beat   = req_valid && req_ready;
   assign seed_write = psel && penable && pwrite && pready && (paddr[3] == REG_SEED);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result beat dropped or changed while stalled");

   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      req_beat && ((req_byte_count != ZERO_COUNT) || req_last) |=> !req_ready)
      else $error("ready while a beat is being hashed");

   a_empty_beat_free: assert property (@(posedge clock) disable iff (reset)
      req_beat && (req_byte_count == ZERO_COUNT) && !req_last |=> req_ready)
      else $error("empty non-last beat stalled the block");

   a_seed_readback: assert property (@(posedge clock) disable iff (reset)
      seed_write ##1 (paddr[3] == REG_SEED) |-> prdata == $past(pwdata))
      else $error("seed read does not return written value");

endmodule

bind murmur64_hash_stream m64h_check u_m64h_check (.*);
